// File: rtl/core/scd_pkg.sv
// shared constants, codes and types of the sheet cache directory
`timescale 1ns / 1ps

package scd_pkg;

  localparam int IDX_W = 8;
  localparam int SLOTS = 256;
  localparam int CNT_W = 9;

  localparam logic [CNT_W-1:0] CAP_RESET = 9'd100;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_TRIM   = 2'd2;

  localparam logic [2:0] STATUS_HIT     = 3'd0;
  localparam logic [2:0] STATUS_LOADED  = 3'd1;
  localparam logic [2:0] STATUS_UNAVAIL = 3'd2;
  localparam logic [2:0] STATUS_BAD     = 3'd3;
  localparam logic [2:0] STATUS_CLEARED = 3'd4;
  localparam logic [2:0] STATUS_TRIMMED = 3'd5;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] idx;
  } scan_stat_t;

endpackage

// File: rtl/core/scd_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module scd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/scd_scan.sv
// oldest-entry search: walks the stamp ram one address a cycle
`timescale 1ns / 1ps

module scd_scan #(
  parameter int SHEET_COUNT = 223,
  parameter int STAMP_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [scd_pkg::SLOTS-1:0]   present,
  output logic [scd_pkg::IDX_W-1:0]   rd_addr,
  input  logic [STAMP_BITS-1:0]       rd_data,
  output scd_pkg::scan_stat_t         stat
);

  import scd_pkg::*;

  localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(SHEET_COUNT);

  logic                  busy;
  logic [CNT_W-1:0]      addr;
  logic                  cmp_valid;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  best_valid;
  logic [STAMP_BITS-1:0] best_stamp;
  logic [IDX_W-1:0]      best_idx;
  logic                  issue;
  logic                  take;

  assign issue   = busy && (addr < LAST_ADDR);
  assign rd_addr = addr[IDX_W-1:0];
  // strict compare keeps the lowest index among equal stamps
  assign take    = cmp_valid && present[cmp_idx] && (!best_valid || rd_data < best_stamp);

  assign stat.done  = busy && !cmp_valid && (addr == LAST_ADDR);
  assign stat.found = best_valid;
  assign stat.idx   = best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      addr       <= '0;
      cmp_valid  <= 1'b0;
      best_valid <= 1'b0;
    end else if (start) begin
      busy       <= 1'b1;
      addr       <= '0;
      cmp_valid  <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      if (stat.done) begin
        busy <= 1'b0;
      end
      cmp_valid <= issue;
      if (issue) begin
        addr <= addr + 1'b1;
      end
      if (take) begin
        best_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx <= addr[IDX_W-1:0];
    end
    if (take) begin
      best_stamp <= rd_data;
      best_idx   <= cmp_idx;
    end
  end

endmodule

// File: rtl/core/sheet_cache_lru_directory_core.sv
// resident sheet directory with least-recently-used eviction, top level
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: func; tdata: sheet_num, sheet_available
//  m_*      out  m_tvalid/m_tready  tuser: status; tdata: eviction info, occupancy, totals
//  cfg_*    in   cfg_wen            cfg_wdata: capacity
//
// an item without eviction is accepted, updated and its result loaded; the
// result is held in an output register so the next beat can be accepted meanwhile.
// each eviction adds a walk in which the stamp ram is read one address a cycle.
// trim repeats that walk once per evicted entry.
// rst is synchronous; presence bits clear at once, no clearing pass is needed.
// a stalled output keeps the next item waiting in its result state, input is held off.
`timescale 1ns / 1ps

module sheet_cache_lru_directory_core #(
  parameter int SHEET_COUNT = 223,
  parameter int STAMP_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // sheet_num[7:0], sheet_available[8], zero fill
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // evicted_valid, evicted_sheet[8:1], evicted_count[17:9],
                                 // occupancy[26:18], hit_total[58:27], miss_total[90:59]
  output logic [2:0]  m_tuser,   // status[2:0]
  input  logic        cfg_wen,
  input  logic [8:0]  cfg_wdata  // capacity
);

  import scd_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  localparam logic [CNT_W-1:0]      SHEET_LIMIT = CNT_W'(SHEET_COUNT);
  localparam logic [STAMP_BITS-1:0] STAMP_MAX   = {STAMP_BITS{1'b1}};
  localparam logic [31:0]           TOTAL_MAX   = 32'hFFFF_FFFF;

  logic [1:0]            state;
  logic [CNT_W-1:0]      capacity;
  logic [SLOTS-1:0]      present;
  logic [CNT_W-1:0]      resident_count;
  logic [STAMP_BITS-1:0] stamp_clock;
  logic [31:0]           hits;
  logic [31:0]           misses;

  logic [1:0]            op;
  logic [IDX_W-1:0]      req_idx;
  logic                  req_avail;
  logic [2:0]            status;
  logic [CNT_W-1:0]      ev_count;
  logic [IDX_W-1:0]      ev_sheet;

  logic [2:0]            out_status;
  logic                  out_ev_valid;
  logic [IDX_W-1:0]      out_ev_sheet;
  logic [CNT_W-1:0]      out_ev_count;
  logic [CNT_W-1:0]      out_occupancy;
  logic [31:0]           out_hits;
  logic [31:0]           out_misses;

  logic                  bad_idx;
  logic                  is_hit;
  logic                  is_insert;
  logic [CNT_W-1:0]      count_inc;
  logic [CNT_W-1:0]      count_dec;
  logic                  stamp_we;
  logic                  scan_start;
  logic                  load_out;
  logic [STAMP_BITS-1:0] stamp_next;
  logic [IDX_W-1:0]      rd_addr;
  logic [STAMP_BITS-1:0] rd_data;
  scan_stat_t            scan_stat;

  assign s_tready  = (state == ST_IDLE);
  assign bad_idx   = {1'b0, req_idx} >= SHEET_LIMIT;
  assign is_hit    = (op == FUNC_LOOKUP) && !bad_idx && present[req_idx];
  assign is_insert = (op == FUNC_LOOKUP) && !bad_idx && !present[req_idx] && req_avail;
  assign count_inc = resident_count + 1'b1;
  assign count_dec = resident_count - 1'b1;
  assign stamp_we  = (state == ST_EXEC) && (is_hit || is_insert);
  assign stamp_next = (stamp_clock != STAMP_MAX) ? stamp_clock + 1'b1 : stamp_clock;
  assign load_out  = (state == ST_RESULT) && (!m_tvalid || m_tready);

  // a trim walks again while occupancy stays above capacity
  always_comb begin
    scan_start = 1'b0;
    if (state == ST_EXEC) begin
      scan_start = (is_insert && count_inc > capacity) ||
                   (op == FUNC_TRIM && resident_count > capacity);
    end else if (state == ST_SCAN) begin
      scan_start = scan_stat.done && scan_stat.found && (op == FUNC_TRIM) &&
                   (count_dec > capacity);
    end
  end

  scd_ram #(
    .WIDTH(STAMP_BITS),
    .DEPTH(SLOTS)
  ) u_stamp_ram (
    .clk  (clk),
    .we   (stamp_we),
    .waddr(req_idx),
    .wdata(stamp_clock),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  scd_scan #(
    .SHEET_COUNT(SHEET_COUNT),
    .STAMP_BITS (STAMP_BITS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_start),
    .present(present),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .stat   (scan_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      present        <= '0;
      resident_count <= '0;
      stamp_clock    <= '0;
      hits           <= '0;
      misses         <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= scan_start ? ST_SCAN : ST_RESULT;
          if (stamp_we) begin
            stamp_clock <= stamp_next;
          end
          if (is_hit && hits != TOTAL_MAX) begin
            hits <= hits + 1'b1;
          end
          if ((op == FUNC_LOOKUP) && !bad_idx && !present[req_idx] && misses != TOTAL_MAX) begin
            misses <= misses + 1'b1;
          end
          if (is_insert) begin
            present[req_idx] <= 1'b1;
            resident_count   <= count_inc;
          end
          if (op == FUNC_CLEAR) begin
            present        <= '0;
            resident_count <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_stat.done) begin
            if (scan_stat.found) begin
              present[scan_stat.idx] <= 1'b0;
              resident_count         <= count_dec;
            end
            if (!scan_start) begin
              state <= ST_RESULT;
            end
          end
        end
        ST_RESULT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // working registers of the item in flight
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      op        <= s_tuser;
      req_idx   <= s_tdata[7:0];
      req_avail <= s_tdata[8];
      ev_count  <= '0;
      ev_sheet  <= '0;
    end
    if (state == ST_EXEC) begin
      priority if (op == FUNC_LOOKUP && bad_idx) begin
        status <= STATUS_BAD;
      end else if (is_hit) begin
        status <= STATUS_HIT;
      end else if (is_insert) begin
        status <= STATUS_LOADED;
      end else if (op == FUNC_LOOKUP) begin
        status <= STATUS_UNAVAIL;
      end else if (op == FUNC_CLEAR) begin
        status <= STATUS_CLEARED;
      end else if (op == FUNC_TRIM) begin
        status <= STATUS_TRIMMED;
      end else begin
        status <= STATUS_BAD;
      end
    end
    if (state == ST_SCAN && scan_stat.done && scan_stat.found) begin
      ev_count <= ev_count + 1'b1;
      ev_sheet <= scan_stat.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status    <= status;
      out_ev_valid  <= (ev_count != '0);
      out_ev_sheet  <= ev_sheet;
      out_ev_count  <= ev_count;
      out_occupancy <= resident_count;
      out_hits      <= hits;
      out_misses    <= misses;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {5'b0, out_misses, out_hits, out_occupancy, out_ev_count,
                    out_ev_sheet, out_ev_valid};

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(present) == int'(resident_count))
    else $error("resident count differs from presence bits");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    resident_count <= SHEET_LIMIT)
    else $error("occupancy beyond sheet count");

  a_victim_gone: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_stat.done && scan_stat.found) |=> !present[$past(scan_stat.idx)])
    else $error("evicted entry still present");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_RESULT)
    else $error("output loaded outside result state");

endmodule
